FILE: rtl/spac_pkg.sv
// Shared types and constants of the submerged polygon area and centroid unit.
`default_nettype none
package spac_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned VcntW = 9;
  localparam int unsigned CoordW = 16;
  localparam int unsigned AreaW = 42;
  localparam int unsigned MomW = 60;
  localparam int unsigned DivW = 64;
  localparam logic [9:0] ClipCntMax = 10'd1023;
  localparam logic [VcntW-1:0] VcntMax = 9'd511;

  // Divider request and response.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/spac_divider.sv
// Serial unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module spac_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire spac_pkg::div_req_t  req_i,
  output spac_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned W = spac_pkg::DivW;

  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] den_q, den_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 7'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("busy at done");
  a_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 7'd0) else $error("count left over");
`endif

endmodule
`default_nettype wire

FILE: rtl/submerged_polygon_area_centroid_unit.sv
// Top level: vertex intake, sequencer, shared multiplier and result register.
//
// Usage: write water_level (signed Q7.8) on cfg_valid_i/cfg_ready_o/cfg_data_i;
// cfg_ready_o is high only while the sequencer is idle. Vertices enter on
// s_axis, one item per vertex: tdata = {vertex_y, vertex_x}, tlast marks the
// final vertex. On a tlast item one result item leaves on m_axis:
// tdata = {centroid_y, centroid_x, submerged_area}, tuser = empty_res.
// Timing: s_axis_tready is low while a vertex is in work. A first vertex that
// is not the last one is stored without leaving the idle state. A crossing
// runs the 17x34 multiplier once and the 64 bit serial divider to get the
// clipped x; every clipped point after the first runs the products for the
// shoelace and moment sums in StMul1 to StMul4. The last vertex adds the
// closing edge, the closing sum and two centroid divisions.
// Reset: clears all polygon state, sets water_level to zero; no result pending.
// Stall: a result waits in the output register while m_axis_tready is low;
// further vertices are taken until the next result is ready to leave.
`default_nettype none
module submerged_polygon_area_centroid_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // vertex_x, vertex_y
  input  wire logic        s_axis_tlast,   // last_vertex
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // submerged_area, centroid_x, centroid_y
  output logic             m_axis_tuser    // empty_res
);

  localparam int unsigned W = spac_pkg::DivW;

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StEdge  = 13'b0000000000010,
    StXmul  = 13'b0000000000100,
    StXdiv  = 13'b0000000001000,
    StDivW  = 13'b0000000010000,
    StEmit  = 13'b0000000100000,
    StMul1  = 13'b0000001000000,
    StMul2  = 13'b0000010000000,
    StMul3  = 13'b0000100000000,
    StMul4  = 13'b0001000000000,
    StFinal = 13'b0010000000000,
    StCdiv  = 13'b0100000000000,
    StOut   = 13'b1000000000000
  } state_e;

  state_e state_q;

  logic signed [15:0] wl_q;
  logic started_q;
  logic signed [15:0] fx_q, fy_q, px_q, py_q, cx_q, cy_q;
  logic signed [15:0] fcx_q, fcy_q, lcx_q, lcy_q;
  logic signed [15:0] ex_q;
  logic [9:0] ccnt_q;
  logic [spac_pkg::VcntW-1:0] vcnt_q;
  logic signed [spac_pkg::AreaW-1:0] area_q;
  logic signed [spac_pkg::MomW-1:0] mx_q, my_q;
  logic last_q;
  logic phase_q;       // 0: edge prev->cur, 1: closing edge cur->first
  logic cross_q;       // crossing point pending emit
  logic keep_q;        // end point pending emit
  logic closing_q;     // closing accumulate pending
  logic closed_q;      // closing accumulate done
  logic neg_q;
  logic cidx_q;        // centroid division index
  logic signed [33:0] cr_q;
  logic signed [50:0] prod_q;
  logic [63:0]  res_q;
  logic         rempty_q;

  logic         ovalid_q;
  logic [63:0]  odata_q;
  logic         oempty_q;
  logic         out_load;

  spac_pkg::div_req_t dreq;
  spac_pkg::div_rsp_t drsp;

  spac_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic in_acc;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == StIdle);
  assign out_load = (state_q == StOut) && (!ovalid_q || m_axis_tready);

  // edge endpoints for current phase
  logic signed [15:0] ax, ay, bx, by;
  always_comb begin
    if (phase_q) begin
      ax = cx_q; ay = cy_q; bx = fx_q; by = fy_q;
    end else begin
      ax = px_q; ay = py_q; bx = cx_q; by = cy_q;
    end
  end

  logic ain, bin;
  assign ain = ay <= wl_q;
  assign bin = by <= wl_q;

  logic signed [16:0] dy, dx, dw, ady;
  assign dy = 17'(by) - 17'(ay);
  assign dx = 17'(bx) - 17'(ax);
  assign dw = 17'(wl_q) - 17'(ay);
  assign ady = dy[16] ? -dy : dy;

  // point to emit: closing pair, crossing, or kept end point
  logic signed [15:0] pt_x, pt_y;
  always_comb begin
    if (closing_q) begin
      pt_x = fcx_q; pt_y = fcy_q;
    end else if (cross_q) begin
      pt_x = ex_q; pt_y = wl_q;
    end else begin
      pt_x = bx; pt_y = by;
    end
  end

  // shared multiplier
  logic signed [16:0] op_a;
  logic signed [33:0] op_b;
  logic signed [50:0] mul;
  always_comb begin
    case (state_q)
      StXmul: begin
        op_a = dw; op_b = 34'(dx);
      end
      StMul1: begin
        op_a = 17'(lcx_q); op_b = 34'(pt_y);
      end
      StMul2: begin
        op_a = 17'(pt_x); op_b = 34'(lcy_q);
      end
      StMul3: begin
        op_a = 17'(lcx_q) + 17'(pt_x); op_b = cr_q;
      end
      StMul4: begin
        op_a = 17'(lcy_q) + 17'(pt_y); op_b = cr_q;
      end
      default: begin
        op_a = '0; op_b = '0;
      end
    endcase
  end
  assign mul = op_a * op_b;

  // signed quotient with rounding: q = (2|n| + |d|) / (2|d|)
  logic signed [63:0] divq_s;
  assign divq_s = neg_q ? -$signed(drsp.quo) : $signed(drsp.quo);
  logic signed [18:0] xsum;
  assign xsum = 19'(ax) + 19'($signed(divq_s[17:0]));
  logic big;
  assign big = !(divq_s[63:17] == '0 || divq_s[63:17] == '1);
  logic signed [15:0] xsat;
  always_comb begin
    if (big) xsat = divq_s[63] ? -16'sd32768 : 16'sd32767;
    else if (xsum > 19'sd32767) xsat = 16'sd32767;
    else if (xsum < -19'sd32768) xsat = -16'sd32768;
    else xsat = xsum[15:0];
  end
  logic signed [15:0] qsat;
  always_comb begin
    if (divq_s > 64'sd32767) qsat = 16'sd32767;
    else if (divq_s < -64'sd32768) qsat = -16'sd32768;
    else qsat = divq_s[15:0];
  end

  logic [W-1:0] pabs;
  assign pabs = prod_q[50] ? W'(-prod_q) : W'(prod_q);
  logic [W-1:0] abs_area;
  assign abs_area = area_q[spac_pkg::AreaW-1] ? W'(-area_q) : W'(area_q);
  logic [W-1:0] d3;
  assign d3 = (abs_area << 1) + abs_area;
  logic signed [spac_pkg::MomW-1:0] msel;
  assign msel = (state_q == StFinal) ? mx_q : my_q;
  logic [W-1:0] mabs;
  assign mabs = msel[spac_pkg::MomW-1] ? W'(-msel) : W'(msel);
  logic [W-1:0] half_area;
  assign half_area = (abs_area + W'(1)) >> 1;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = '0;
    if (state_q == StXdiv) begin
      dreq.start = 1'b1;
      dreq.num = (pabs << 1) + W'(ady);
      dreq.den = W'(ady) << 1;
    end else if (state_q == StFinal || (state_q == StCdiv && drsp.done && !cidx_q)) begin
      dreq.start = 1'b1;
      dreq.num = (mabs << 1) + d3;
      dreq.den = d3 << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wl_q <= '0;
      started_q <= 1'b0;
      ccnt_q <= '0;
      vcnt_q <= '0;
      area_q <= '0;
      mx_q <= '0;
      my_q <= '0;
      phase_q <= 1'b0;
      cross_q <= 1'b0;
      keep_q <= 1'b0;
      closing_q <= 1'b0;
      closed_q <= 1'b0;
      neg_q <= 1'b0;
      cidx_q <= 1'b0;
      last_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; px_q <= '0; py_q <= '0;
      cx_q <= '0; cy_q <= '0; ex_q <= '0;
      fcx_q <= '0; fcy_q <= '0; lcx_q <= '0; lcy_q <= '0;
      cr_q <= '0; prod_q <= '0;
      res_q <= '0; rempty_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) wl_q <= cfg_data_i;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            cx_q <= s_axis_tdata[15:0];
            cy_q <= s_axis_tdata[31:16];
            last_q <= s_axis_tlast;
            if (!started_q) begin
              started_q <= 1'b1;
              fx_q <= s_axis_tdata[15:0];
              fy_q <= s_axis_tdata[31:16];
              vcnt_q <= spac_pkg::VcntW'(1);
              if (s_axis_tlast) begin
                phase_q <= 1'b1;
                state_q <= StEdge;
              end else begin
                px_q <= s_axis_tdata[15:0];
                py_q <= s_axis_tdata[31:16];
              end
            end else if (32'(vcnt_q) >= spac_pkg::MaxVertices && !s_axis_tlast) begin
              state_q <= StIdle;
            end else begin
              if (vcnt_q < spac_pkg::VcntMax) vcnt_q <= vcnt_q + spac_pkg::VcntW'(1);
              state_q <= StEdge;
            end
          end
        end
        StEdge: begin
          cross_q <= ain != bin;
          keep_q <= bin;
          state_q <= (ain != bin) ? StXmul : StEmit;
        end
        StXmul: begin
          prod_q <= mul;
          state_q <= StXdiv;
        end
        StXdiv: begin
          neg_q <= prod_q[50] ^ dy[16];
          state_q <= StDivW;
        end
        StDivW: if (drsp.done) begin
          ex_q <= xsat;
          state_q <= StEmit;
        end
        StEmit: begin
          if (cross_q || keep_q || closing_q) begin
            if (ccnt_q != 10'd0) begin
              state_q <= StMul1;
            end else begin
              fcx_q <= pt_x; fcy_q <= pt_y;
              lcx_q <= pt_x; lcy_q <= pt_y;
              ccnt_q <= ccnt_q + 10'd1;
              if (cross_q) cross_q <= 1'b0; else keep_q <= 1'b0;
            end
          end else if (!phase_q && last_q) begin
            phase_q <= 1'b1;
            state_q <= StEdge;
          end else if (phase_q && !closed_q && ccnt_q >= 10'd2) begin
            closing_q <= 1'b1;
            closed_q <= 1'b1;
          end else if (last_q) begin
            if (ccnt_q < 10'd3 || area_q == '0) begin
              res_q <= '0;
              rempty_q <= 1'b1;
              state_q <= StOut;
            end else begin
              res_q[31:0] <= (half_area > W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF
                             : half_area[31:0];
              rempty_q <= 1'b0;
              neg_q <= mx_q[spac_pkg::MomW-1] ^ area_q[spac_pkg::AreaW-1];
              state_q <= StFinal;
            end
          end else begin
            px_q <= cx_q; py_q <= cy_q;
            state_q <= StIdle;
          end
        end
        StMul1: begin
          prod_q <= mul;
          state_q <= StMul2;
        end
        StMul2: begin
          cr_q <= 34'(prod_q - mul);
          area_q <= area_q + spac_pkg::AreaW'(prod_q - mul);
          state_q <= StMul3;
        end
        StMul3: begin
          mx_q <= mx_q + spac_pkg::MomW'(mul);
          state_q <= StMul4;
        end
        StMul4: begin
          my_q <= my_q + spac_pkg::MomW'(mul);
          if (closing_q) begin
            closing_q <= 1'b0;
          end else begin
            lcx_q <= pt_x; lcy_q <= pt_y;
            if (ccnt_q < spac_pkg::ClipCntMax) ccnt_q <= ccnt_q + 10'd1;
            if (cross_q) cross_q <= 1'b0; else keep_q <= 1'b0;
          end
          state_q <= StEmit;
        end
        StFinal: begin
          cidx_q <= 1'b0;
          state_q <= StCdiv;
        end
        StCdiv: if (drsp.done) begin
          if (!cidx_q) begin
            res_q[47:32] <= qsat;
            cidx_q <= 1'b1;
            neg_q <= my_q[spac_pkg::MomW-1] ^ area_q[spac_pkg::AreaW-1];
          end else begin
            res_q[63:48] <= qsat;
            state_q <= StOut;
          end
        end
        StOut: if (out_load) begin
          state_q <= StIdle;
          started_q <= 1'b0;
          fx_q <= '0; fy_q <= '0; px_q <= '0; py_q <= '0;
          fcx_q <= '0; fcy_q <= '0; lcx_q <= '0; lcy_q <= '0;
          ccnt_q <= '0; vcnt_q <= '0;
          area_q <= '0; mx_q <= '0; my_q <= '0;
          cidx_q <= 1'b0; last_q <= 1'b0; closing_q <= 1'b0;
          closed_q <= 1'b0; phase_q <= 1'b0;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      odata_q <= '0;
      oempty_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
      odata_q <= res_q;
      oempty_q <= rempty_q;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oempty_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("empty nonzero");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_submerged_polygon_area_centroid_unit.sv
// Testbench for the submerged polygon area and centroid unit: random polygons, self-checking.
`timescale 1ns / 1ps
module tb_submerged_polygon_area_centroid_unit;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  typedef struct {
    logic [31:0]        area;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               empty;
  } hull_res_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  submerged_polygon_area_centroid_unit u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Predictor state
  longint lvl;
  bit     pg_started;
  longint fx, fy, px, py, fcx, fcy, lcx, lcy;
  int     ncl, nvert;
  longint a_sum, mx_sum, my_sum;

  vertex_t   vtx_q[$];
  hull_res_t expected_q[$];
  int        n_accepted, n_results, n_mismatch, n_polys, n_empty;
  int        idle_cnt;
  int        hold_cycles;
  bit        done_feeding;

  function automatic longint div_round(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void add_edge(longint ax, longint ay, longint bx, longint by);
    longint cr;
    cr = ax * by - bx * ay;
    a_sum += cr;
    mx_sum += (ax + bx) * cr;
    my_sum += (ay + by) * cr;
  endfunction

  function automatic void add_point(longint x, longint y);
    if (ncl == 0) begin
      fcx = x;
      fcy = y;
    end else begin
      add_edge(lcx, lcy, x, y);
    end
    lcx = x;
    lcy = y;
    if (ncl < 1023) ncl++;
  endfunction

  function automatic void clip_to_water(longint ax, longint ay, longint bx, longint by);
    bit ain, bin;
    ain = ay <= lvl;
    bin = by <= lvl;
    if (ain != bin)
      add_point(clamp16(ax + div_round((lvl - ay) * (bx - ax), by - ay)), lvl);
    if (bin) add_point(bx, by);
  endfunction

  function automatic void clear_polygon();
    pg_started = 0;
    ncl = 0;
    nvert = 0;
    a_sum = 0;
    mx_sum = 0;
    my_sum = 0;
  endfunction

  function automatic void predict_submerged(vertex_t v);
    longint x, y, a2, ar, d;
    hull_res_t r;
    x = v.x;
    y = v.y;
    if (!pg_started) begin
      pg_started = 1;
      fx = x;
      fy = y;
      nvert = 1;
    end else begin
      if (nvert >= spac_pkg::MaxVertices && !v.last) return;
      clip_to_water(px, py, x, y);
      if (nvert < 511) nvert++;
    end
    px = x;
    py = y;
    if (!v.last) return;
    clip_to_water(x, y, fx, fy);
    if (ncl >= 2) add_edge(lcx, lcy, fcx, fcy);
    if (ncl < 3 || a_sum == 0) begin
      r = '{32'd0, 16'sd0, 16'sd0, 1'b1};
    end else begin
      a2 = a_sum < 0 ? -a_sum : a_sum;
      ar = (a2 + 1) >>> 1;
      if (ar > 64'hFFFF_FFFF) ar = 64'hFFFF_FFFF;
      d = 3 * a_sum;
      r.area = ar[31:0];
      r.cx = 16'(clamp16(div_round(mx_sum, d)));
      r.cy = 16'(clamp16(div_round(my_sum, d)));
      r.empty = 0;
    end
    expected_q.insert(expected_q.size(), r);
    clear_polygon();
  endfunction

  // Driver
  int src_wait;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_submerged(vtx_q.pop_front());
      n_accepted++;
      src_wait = $urandom_range(0, 4);
    end
    if (s_axis_tvalid && !s_axis_tready) begin
    end else if (src_wait > 0) begin
      src_wait--;
      s_axis_tvalid <= 0;
    end else if (vtx_q.size() > 0 && rst_ni && !(s_axis_tvalid && s_axis_tready
               && vtx_q.size() == 0)) begin
      s_axis_tvalid <= 1;
      s_axis_tdata  <= {vtx_q[0].y, vtx_q[0].x};
      s_axis_tlast  <= vtx_q[0].last;
    end else begin
      s_axis_tvalid <= 0;
    end
  end

  // Long receiver stall counter
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Monitor
  int snk_wait;
  always @(posedge clk_i) begin
    hull_res_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        e = expected_q.pop_front();
        if (e.empty) n_empty++;
        if (m_axis_tdata !== {e.cy, e.cx, e.area} || m_axis_tuser !== e.empty) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp area %h cx %h cy %h empty %b, got %h user %b",
                     e.area, e.cx, e.cy, e.empty, m_axis_tdata, m_axis_tuser);
        end
      end
      snk_wait = $urandom_range(0, 4);
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 0;
    end else if (snk_wait > 0) begin
      snk_wait--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_vertex(int x, int y, bit last);
    vertex_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.last = last;
    vtx_q.insert(vtx_q.size(), v);
  endtask

  task automatic add_random_polygon(int nv, int span);
    int cx, cy, r, ang;
    cx = $urandom_range(0, 2 * span) - span;
    cy = int'(lvl) + $urandom_range(0, 2 * span) - span;
    for (int i = 0; i < nv; i++) begin
      r = $urandom_range(1, span);
      ang = i * 360 / nv;
      add_vertex(int'(clamp16(longint'(cx + r * $cos(ang * 3.14159 / 180.0)))),
                 int'(clamp16(longint'(cy + r * $sin(ang * 3.14159 / 180.0)))),
                 i == nv - 1);
      n_polys += (i == nv - 1);
    end
  endtask

  task automatic drain();
    while (vtx_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_level(int val);
    cfg_valid_i <= 1;
    cfg_data_i <= val[15:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    lvl = longint'(signed'(val[15:0]));
  endtask

  initial begin
    int levels[5];
    clear_polygon();
    lvl = 0;
    src_wait = 0;
    snk_wait = 0;
    hold_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, single vertex, degenerate, crossings
    add_vertex(100, 100, 1);
    add_vertex(-32768, -32768, 0);
    add_vertex(32767, -32768, 0);
    add_vertex(32767, 32767, 0);
    add_vertex(-32768, 32767, 1);
    add_vertex(0, 0, 0);
    add_vertex(256, 0, 0);
    add_vertex(512, 0, 1);
    add_vertex(-256, -512, 0);
    add_vertex(256, 512, 0);
    add_vertex(-512, 256, 1);
    add_vertex(0, 256, 0);
    add_vertex(256, 512, 0);
    add_vertex(-256, 512, 1);
    add_vertex(-32768, 32767, 0);
    add_vertex(32767, -32768, 0);
    add_vertex(32767, 32767, 1);
    n_polys += 6;
    drain();

    // Too many vertices: last must still close
    for (int i = 0; i < 260; i++)
      add_vertex(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)), i == 259);
    n_polys++;
    // Stall the output while polygons keep coming
    add_random_polygon(3, 2000);
    add_random_polygon(3, 2000);
    add_random_polygon(4, 2000);
    hold_cycles = 3000;
    drain();

    levels = '{-32768, 32767, 1234, -700, 0};
    foreach (levels[k]) begin
      write_level(levels[k]);
      repeat (25) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int i = 0; i < 4; i++)
            add_vertex(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                       i == 3 || $urandom_range(0, 7) == 0);
        end else
          add_random_polygon($urandom_range(3, 8),
                             $urandom_range(0, 3) == 0 ? 30000 : $urandom_range(4, 4000));
      end
      n_polys += 0;
      drain();
    end

    $display("Checked %0d vertices, %0d results (%0d empty), %0d generated polygons,",
             n_accepted, n_results, n_empty, n_polys);
    $display("five water levels incl. extremes, vertex overflow and a long output stall.");
    if (n_mismatch == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/spac_pkg.sv
rtl/spac_divider.sv
rtl/submerged_polygon_area_centroid_unit.sv
bench/tb_submerged_polygon_area_centroid_unit.sv
